### hdl/lts_pkg.sv
package lts_pkg;

  localparam int unsigned KEY_W    = 42;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned ACTIVE_W = 7;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 7'd64;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FILL   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  // one slot as held in the slot memory
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

### hdl/lts_req_if.sv
interface lts_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  source_id;
  logic [7:0]  zoom_level;
  logic [15:0] tile_x;
  logic [15:0] tile_y;

  modport source (output valid, cmd, source_id, zoom_level, tile_x, tile_y, input ready);
  modport sink (input valid, cmd, source_id, zoom_level, tile_x, tile_y, output ready);
endinterface

### hdl/lts_rsp_if.sv
interface lts_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [5:0] slot;

  modport source (output valid, hit, slot, input ready);
  modport sink (input valid, hit, slot, output ready);
endinterface

### hdl/lts_cfg_if.sv
interface lts_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hdl/lru_tile_tag_store.sv
// scan: an accepted item reads the n live slots in order, one slot per cycle, and stops
// early on a lookup hit or on an empty slot for a fill
// no new item is taken until the result has moved to the output register, so a result
// left waiting holds the next one back
// reset: counter cleared, active_slots back to 64, then a clearing pass over all SLOTS
// slots writes every valid bit to zero while no item is taken (config writes still taken)
module lru_tile_tag_store #(
  parameter int unsigned SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lts_req_if.sink    req_i,
  lts_rsp_if.source  rsp_o,
  lts_cfg_if.sink    cfg_i
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = IW + 1;

  // sequencer state
  lts_pkg::state_e state_q, state_d;

  // configuration
  logic [lts_pkg::ACTIVE_W-1:0] active_q;
  logic [CW-1:0]                n_live;

  // the item under work
  lts_pkg::cmd_e               cmd_q;
  logic [lts_pkg::KEY_W-1:0]   key_q;
  logic [CW-1:0]               n_q;

  // scan pipeline: read issue counter and the compare stage behind it
  logic [CW-1:0]  rd_cnt_q, rd_cnt_d;
  logic           pend_q, pend_d;
  logic [IW-1:0]  pend_idx_q;

  // least-stamp tracking for fills
  logic [IW-1:0]                best_q, best_d;
  logic [lts_pkg::STAMP_W-1:0]  low_stamp_q, low_stamp_d;
  logic [IW-1:0]                victim_q, victim_d;

  // global use counter
  logic [lts_pkg::STAMP_W-1:0]  ctr_q;

  // clearing pass
  logic [IW-1:0] clr_idx_q;

  // result waiting for the output register, and the output register
  logic                       res_hit_q;
  logic [lts_pkg::SLOT_W-1:0] res_slot_q;
  logic                       rsp_valid_q;
  logic                       rsp_hit_q;
  logic [lts_pkg::SLOT_W-1:0] rsp_slot_q;
  logic                       rsp_load;

  // slot memory
  lts_pkg::entry_t mem_q [SLOTS];
  lts_pkg::entry_t rdata_q;
  logic            rd_en;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  lts_pkg::entry_t wr_data;

  // compare stage
  logic req_acc;
  logic scan_last;
  logic look_hit;
  logic fill_free;
  logic better;

  assign req_acc   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == lts_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.hit   = rsp_hit_q;
  assign rsp_o.slot  = rsp_slot_q;

  // zero counts as one, anything past SLOTS saturates
  always_comb begin
    if (active_q == '0) begin
      n_live = CW'(1);
    end else if (32'(active_q) > SLOTS) begin
      n_live = CW'(SLOTS);
    end else begin
      n_live = CW'(active_q);
    end
  end

  // what the slot read last cycle says
  assign scan_last = pend_q && ({1'b0, pend_idx_q} == (n_q - CW'(1)));
  assign look_hit  = pend_q && (cmd_q == lts_pkg::CMD_LOOKUP) && rdata_q.valid
                     && (rdata_q.key == key_q);
  assign fill_free = pend_q && (cmd_q == lts_pkg::CMD_FILL) && !rdata_q.valid;
  // strict less-than keeps the lowest index among equal stamps
  assign better    = pend_q && (cmd_q == lts_pkg::CMD_FILL) && rdata_q.valid
                     && (rdata_q.stamp < low_stamp_q);

  assign best_d      = better ? pend_idx_q : best_q;
  assign low_stamp_d = better ? rdata_q.stamp : low_stamp_q;
  assign rsp_load    = !rsp_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lts_pkg::ST_CLEAR: begin
        if (clr_idx_q == IW'(SLOTS - 1)) begin
          state_d = lts_pkg::ST_IDLE;
        end
      end
      lts_pkg::ST_IDLE: begin
        if (req_acc) begin
          state_d = lts_pkg::ST_SCAN;
        end
      end
      lts_pkg::ST_SCAN: begin
        if (look_hit || fill_free) begin
          state_d = lts_pkg::ST_WRITE;
        end else if (scan_last) begin
          state_d = (cmd_q == lts_pkg::CMD_FILL) ? lts_pkg::ST_WRITE : lts_pkg::ST_DONE;
        end
      end
      lts_pkg::ST_WRITE: begin
        state_d = lts_pkg::ST_DONE;
      end
      lts_pkg::ST_DONE: begin
        if (rsp_load) begin
          state_d = lts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lts_pkg::ST_CLEAR;
      end
    endcase
  end

  // memory control and scan bookkeeping
  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = victim_q;
    wr_data  = '{valid: 1'b1, key: key_q, stamp: ctr_q + 32'd1};
    rd_cnt_d = rd_cnt_q;
    pend_d   = 1'b0;
    victim_d = victim_q;
    unique case (state_q)
      lts_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_q;
        wr_data = '0;
      end
      lts_pkg::ST_SCAN: begin
        // one read issued per cycle until the live range is covered
        rd_en    = (rd_cnt_q < n_q);
        rd_cnt_d = rd_en ? rd_cnt_q + CW'(1) : rd_cnt_q;
        // a read issued as the scan stops is simply dropped
        pend_d   = rd_en && (state_d == lts_pkg::ST_SCAN);
        victim_d = (look_hit || fill_free) ? pend_idx_q : best_d;
      end
      lts_pkg::ST_WRITE: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_cnt_q[IW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lts_pkg::ST_CLEAR;
      active_q    <= lts_pkg::ACTIVE_RST;
      ctr_q       <= '0;
      clr_idx_q   <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (cfg_i.valid && cfg_i.ready) begin
        active_q <= cfg_i.data;
      end
      if (state_q == lts_pkg::ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + IW'(1);
      end
      if (state_q == lts_pkg::ST_WRITE) begin
        ctr_q <= ctr_q + 32'd1;
      end
      if (state_q == lts_pkg::ST_DONE && rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q       <= lts_pkg::cmd_e'(req_i.cmd);
      key_q       <= {req_i.source_id, req_i.zoom_level, req_i.tile_x, req_i.tile_y};
      n_q         <= n_live;
      rd_cnt_q    <= '0;
      best_q      <= '0;
      low_stamp_q <= '1;
    end else if (state_q == lts_pkg::ST_SCAN) begin
      rd_cnt_q    <= rd_cnt_d;
      best_q      <= best_d;
      low_stamp_q <= low_stamp_d;
    end
    if (rd_en) begin
      pend_idx_q <= rd_cnt_q[IW-1:0];
    end
    victim_q <= victim_d;
    if (state_q == lts_pkg::ST_SCAN && scan_last && !look_hit
        && cmd_q == lts_pkg::CMD_LOOKUP) begin
      // lookup miss: nothing stored, slot reads zero
      res_hit_q  <= 1'b0;
      res_slot_q <= '0;
    end else if (state_q == lts_pkg::ST_WRITE) begin
      res_hit_q  <= (cmd_q == lts_pkg::CMD_LOOKUP);
      res_slot_q <= lts_pkg::SLOT_W'(victim_q);
    end
    if (state_q == lts_pkg::ST_DONE && rsp_load) begin
      rsp_hit_q  <= res_hit_q;
      rsp_slot_q <= res_slot_q;
    end
  end

  // the slot written back always lies inside the live range of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lts_pkg::ST_WRITE |-> {1'b0, victim_q} < n_q)
    else $error("write-back slot outside live range");

  // the use counter moves only on a write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != lts_pkg::ST_WRITE |=> $stable(ctr_q))
    else $error("use counter changed without a write-back");

  // the read counter never runs past the live range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lts_pkg::ST_SCAN |-> rd_cnt_q <= n_q)
    else $error("scan read beyond live range");

  // a compare in flight belongs to a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == lts_pkg::ST_SCAN)
    else $error("slot compare outside a scan");

endmodule

### verif/lts_tag_checker.sv
module lts_tag_checker #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lts_req_if          req_mon,
  lts_rsp_if          rsp_mon,
  lts_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o,
  output int unsigned hit_count_o
);

  typedef struct packed {
    logic                       hit;
    logic [lts_pkg::SLOT_W-1:0] slot;
  } tag_result_t;

  // shadow copy of the tag store
  logic [lts_pkg::KEY_W-1:0]    tag_key   [SLOTS];
  bit                           tag_held  [SLOTS];
  logic [lts_pkg::STAMP_W-1:0]  tag_stamp [SLOTS];
  logic [lts_pkg::STAMP_W-1:0]  use_count;
  logic [lts_pkg::ACTIVE_W-1:0] active_slots;

  tag_result_t result_q [$];
  tag_result_t oldest;

  function automatic int unsigned live_slots();
    int unsigned n;
    n = active_slots;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // first empty slot, else least stamp with lowest index among equals
  function automatic int unsigned choose_victim(int unsigned n);
    int unsigned                 best;
    logic [lts_pkg::STAMP_W-1:0] least_stamp;
    best        = 0;
    least_stamp = '1;
    for (int unsigned i = 0; i < n; i++) begin
      if (!tag_held[i]) return i;
      if (tag_stamp[i] < least_stamp) begin
        least_stamp = tag_stamp[i];
        best        = i;
      end
    end
    return best;
  endfunction

  function automatic tag_result_t resolve_request(lts_pkg::cmd_e cmd,
                                                  logic [lts_pkg::KEY_W-1:0] key);
    tag_result_t res;
    int unsigned n;
    int unsigned i;
    n   = live_slots();
    res = '0;
    if (cmd == lts_pkg::CMD_LOOKUP) begin
      for (i = 0; i < n; i++) begin
        if (tag_held[i] && tag_key[i] == key) begin
          use_count    = use_count + 1;
          tag_stamp[i] = use_count;
          res.hit      = 1'b1;
          res.slot     = i[lts_pkg::SLOT_W-1:0];
          return res;
        end
      end
      return res;
    end
    i            = choose_victim(n);
    use_count    = use_count + 1;
    tag_key[i]   = key;
    tag_stamp[i] = use_count;
    tag_held[i]  = 1'b1;
    res.slot     = i[lts_pkg::SLOT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (tag_held[i]) tag_held[i] = 1'b0;
      use_count     = '0;
      active_slots  = lts_pkg::ACTIVE_RST;
      result_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
      hit_count_o   = 0;
    end else begin
      // results first, so a stray one never pairs with an item taken this edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: hit %0d slot %0d", rsp_mon.hit, rsp_mon.slot);
          fail_count_o++;
        end else begin
          oldest = result_q.pop_front();
          if (rsp_mon.hit !== oldest.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", oldest.hit, rsp_mon.hit);
            fail_count_o++;
          end
          if (rsp_mon.slot !== oldest.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", oldest.slot, rsp_mon.slot);
            fail_count_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        result_q.push_back(resolve_request(lts_pkg::cmd_e'(req_mon.cmd),
          {req_mon.source_id, req_mon.zoom_level, req_mon.tile_x, req_mon.tile_y}));
        if (result_q[$].hit) hit_count_o++;
      end
      // an item taken this edge still sees the old live slot count
      if (cfg_mon.valid && cfg_mon.ready) active_slots = cfg_mon.data;
      outstanding_o = result_q.size();
    end
  end

endmodule

### verif/tb_lru_tile_tag_store.sv
module tb_lru_tile_tag_store;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned POOL        = 32;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 48;

  // same field order as the packed key: source, zoom, column, row
  typedef struct packed {
    logic [1:0]  source_id;
    logic [7:0]  zoom_level;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
  } tile_id_t;

  logic clk_i;
  logic rst_ni;

  lts_req_if req_ch ();
  lts_rsp_if rsp_ch ();
  lts_cfg_if cfg_ch ();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned hit_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned cfg_writes;
  bit          calm;        // set for the closing stretch: no gaps, no stalls

  tile_id_t    key_pool [POOL];

  lru_tile_tag_store #(
    .SLOTS (SLOTS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  // watches all three channels, predicts each result and compares
  lts_tag_checker #(
    .SLOTS (SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .cfg_mon       (cfg_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .hit_count_o   (hit_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // guard against a hung handshake
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: ready runs and stall bursts, steady once calm is set
  initial begin
    int unsigned run;
    rsp_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        rsp_ch.ready <= 1'b1;
        run = $urandom_range(1, 30);
      end else begin
        rsp_ch.ready <= 1'b0;
        run = $urandom_range(1, 14);
      end
      repeat (run) @(negedge clk_i);
    end
  end

  // one item on the request channel, entered and left at a falling edge;
  // valid is left high so back-to-back items never drop it
  task automatic send_tile(lts_pkg::cmd_e cmd, tile_id_t key);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.source_id  <= key.source_id;
    req_ch.zoom_level <= key.zoom_level;
    req_ch.tile_x     <= key.tile_x;
    req_ch.tile_y     <= key.tile_y;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // drop the request and wait until every result is back, so the block is idle
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_active(logic [lts_pkg::ACTIVE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    tile_id_t                     zero_key;
    tile_id_t                     ones_key;
    tile_id_t                     key;
    lts_pkg::cmd_e                cmd;
    logic [lts_pkg::ACTIVE_W-1:0] setting [PHASES];
    int unsigned                  live;
    int unsigned                  span;

    // every input known from time zero
    rst_ni            = 1'b0;
    calm              = 1'b0;
    items_sent        = 0;
    cfg_writes        = 0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = lts_pkg::CMD_LOOKUP;
    req_ch.source_id  = '0;
    req_ch.zoom_level = '0;
    req_ch.tile_x     = '0;
    req_ch.tile_y     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;

    // key pool: the two extremes, random keys, and near misses one bit apart
    zero_key    = '0;
    ones_key    = '1;
    key_pool[0] = zero_key;
    key_pool[1] = ones_key;
    for (int unsigned k = 2; k < POOL; k++) begin
      if (k % 4 == 3) begin
        key_pool[k] = key_pool[k-1] ^ (42'd1 << $urandom_range(0, lts_pkg::KEY_W - 1));
      end else begin
        key_pool[k].source_id  = 2'($urandom_range(0, 3));
        key_pool[k].zoom_level = 8'($urandom_range(0, 255));
        key_pool[k].tile_x     = 16'($urandom_range(0, 65535));
        key_pool[k].tile_y     = 16'($urandom_range(0, 65535));
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: all 64 slots live after reset, store empty
    send_tile(lts_pkg::CMD_LOOKUP, zero_key);                   // miss on an empty store
    send_tile(lts_pkg::CMD_FILL, zero_key);                     // first empty slot
    send_tile(lts_pkg::CMD_FILL, ones_key);                     // next empty slot
    send_tile(lts_pkg::CMD_LOOKUP, ones_key);                   // hit, all bits set
    send_tile(lts_pkg::CMD_LOOKUP, zero_key);                   // hit, all bits clear
    send_tile(lts_pkg::CMD_LOOKUP, zero_key ^ (42'd1 << 41));   // near miss in the source
    send_tile(lts_pkg::CMD_LOOKUP, zero_key ^ 42'd1);           // near miss in the row
    send_tile(lts_pkg::CMD_FILL, zero_key);                     // duplicate key, no check
    send_tile(lts_pkg::CMD_LOOKUP, zero_key);                   // lowest duplicate wins
    settle();

    // zero live slots behaves as one
    write_active(7'd0);
    send_tile(lts_pkg::CMD_FILL, key_pool[2]);                  // evicts slot 0
    send_tile(lts_pkg::CMD_LOOKUP, ones_key);                   // held above the range: miss
    send_tile(lts_pkg::CMD_LOOKUP, key_pool[2]);
    settle();

    // above the slot count saturates; shrunk-away slots come back
    write_active(7'd127);
    send_tile(lts_pkg::CMD_LOOKUP, ones_key);
    send_tile(lts_pkg::CMD_LOOKUP, zero_key);                   // now the duplicate
    settle();

    // three live slots, all full: least recently used goes
    write_active(7'd3);
    send_tile(lts_pkg::CMD_FILL, key_pool[3]);
    send_tile(lts_pkg::CMD_FILL, key_pool[4]);
    send_tile(lts_pkg::CMD_LOOKUP, key_pool[3]);
    send_tile(lts_pkg::CMD_LOOKUP, key_pool[4]);
    settle();

    // random phases over a spread of live slot counts, extremes included
    setting = '{7'd4, 7'd1, 7'd64, 7'd2, 7'd16, 7'd100, 7'd0, 7'd8, 7'd127, 7'd5};
    setting[4] = 7'($urandom_range(6, 63));
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      write_active(setting[p]);
      if (p == PHASES - 1) calm = 1'b1;
      live = (setting[p] == 0) ? 1 : (setting[p] > SLOTS) ? SLOTS : setting[p];
      // keep the key spread near the live size so hits and evictions both happen
      span = (live * 2 + 1 < POOL) ? live * 2 + 1 : POOL - 1;
      for (int unsigned j = 0; j < PHASE_ITEMS; j++) begin
        cmd = ($urandom_range(0, 99) < 35) ? lts_pkg::CMD_FILL : lts_pkg::CMD_LOOKUP;
        if ($urandom_range(0, 9) == 0) begin
          key.source_id  = 2'($urandom_range(0, 3));
          key.zoom_level = 8'($urandom_range(0, 255));
          key.tile_x     = 16'($urandom_range(0, 65535));
          key.tile_y     = 16'($urandom_range(0, 65535));
        end else begin
          key = key_pool[$urandom_range(0, span)];
        end
        send_tile(cmd, key);
      end
    end

    settle();
    // a late stray result would still show up in the failure count
    repeat (80) @(negedge clk_i);

    $display("run covered %0d requests (%0d lookup hits) under %0d live slot settings",
             items_sent, hit_count, cfg_writes);
    $display("settings spanned zero, one, full, above range and shrink back");
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hdl/lts_pkg.sv
hdl/lts_req_if.sv
hdl/lts_rsp_if.sv
hdl/lts_cfg_if.sv
hdl/lru_tile_tag_store.sv
verif/lts_tag_checker.sv
verif/tb_lru_tile_tag_store.sv
